[hdl/dsmr_pkg.sv]
// Package with shared types, constants and the block-count function of the DSM reassembler.
`timescale 1ns / 1ps
package dsmr_pkg;
	localparam int NUM_PRN = 64;
	localparam int BLOCKS_PER_DSM = 16;
	localparam int BLOCK_BYTES = 13;
	localparam int NUM_DSM_IDS = 16;

	localparam int PRN_IDX_W = (NUM_PRN > 2) ? $clog2(NUM_PRN) : 1;
	localparam int ID_W = $clog2(NUM_DSM_IDS);
	localparam int BLK_W = $clog2(BLOCKS_PER_DSM);
	localparam int SLOT_W = PRN_IDX_W + ID_W;
	localparam int NUM_SLOTS = NUM_PRN * NUM_DSM_IDS;
	localparam int BLK_ADDR_W = SLOT_W + BLK_W;
	localparam int BLOCK_W = BLOCK_BYTES * 8;
	localparam int BUF_W = BLOCK_W + 56;

	localparam logic [3:0] PKR_FIRST_ID = 4'd12;

	typedef enum logic [1:0] {
		ST_REJECT = 2'd0,
		ST_STORED = 2'd1,
		ST_WORD = 2'd2
	} status_t;

	typedef struct packed {
		logic active;
		logic done;
		logic has_first;
		logic [15:0] rx_map;
		logic [31:0] first_epoch;
		logic [7:0] nma;
		logic [3:0] nb;
	} slot_t;

	typedef struct packed {
		status_t kind;
		logic [5:0] prn;
		logic [3:0] id;
		logic [7:0] nma;
		logic [4:0] nblocks;
		logic [SLOT_W-1:0] slot;
		logic [31:0] epoch;
		logic [31:0] exp_kroot;
		logic [31:0] exp_pkr;
	} cmd_t;

	function automatic logic [4:0] nb_to_blocks(input logic pkr, input logic [3:0] nb);
		logic [4:0] r;
		r = 5'd0;
		if (pkr) begin
			if (nb >= 4'd7 && nb <= 4'd10) r = 5'({1'b0, nb} + 5'd6);
		end else begin
			if (nb >= 4'd1 && nb <= 4'd8) r = 5'({1'b0, nb} + 5'd6);
		end
		return r;
	endfunction
endpackage

[hdl/dsmr_queue.sv]
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps
module dsmr_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dsmr_pkg::cmd_t push_cmd,
	input logic pop,
	output dsmr_pkg::cmd_t head_cmd,
	output logic full,
	output logic empty
);
	import dsmr_pkg::*;

	cmd_t q0_q, q1_q;
	logic [1:0] cnt_q;

	assign head_cmd = q0_q;
	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) q0_q <= push_cmd;
			else q1_q <= push_cmd;
		end else if (pop && !push) begin
			q0_q <= q1_q;
		end else if (pop && push) begin
			if (cnt_q == 2'd1) begin
				q0_q <= push_cmd;
			end else begin
				q0_q <= q1_q;
				q1_q <= push_cmd;
			end
		end
	end
endmodule

[hdl/dsmr_front.sv]
// Front part: accepts blocks, updates the slot table and issues commands to the back part.
`timescale 1ns / 1ps
module dsmr_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [5:0] prn,
	input logic [7:0] dsm_header_byte,
	input logic [63:0] data_head,
	input logic [39:0] data_tail,
	input logic [7:0] nma_hdr,
	input logic [31:0] epoch_seconds,
	input logic epoch_valid,
	input logic [31:0] kroot_max_age,
	input logic [31:0] pkr_max_age,
	input logic q_full,
	output logic q_push,
	output dsmr_pkg::cmd_t q_cmd,
	input logic msg_done,
	output logic blk_we,
	output logic [dsmr_pkg::BLK_ADDR_W-1:0] blk_waddr,
	output logic [dsmr_pkg::BLOCK_W-1:0] blk_wdata
);
	import dsmr_pkg::*;

	typedef enum logic [3:0] {
		F_CLEAR = 4'b0001,
		F_IDLE = 4'b0010,
		F_READ = 4'b0100,
		F_EVAL = 4'b1000
	} fstate_t;

	fstate_t state_q;
	slot_t slot_mem [NUM_SLOTS];
	slot_t rd_q;
	logic [SLOT_W:0] clr_q;
	logic msg_wait_q;
	logic [31:0] exp_kroot_q, exp_pkr_q;

	logic [5:0] prn_q;
	logic [3:0] id_q, blk_q;
	logic [63:0] head_q;
	logic [39:0] tail_q;
	logic [7:0] nma_q;
	logic [31:0] ep_q;
	logic ep_ok_q;

	logic [SLOT_W-1:0] slot;
	logic [7:0] prn_ext;
	logic bad, pkr, expired, restart, complete;
	logic [31:0] max_age, age, kr_next, pk_next;
	slot_t nxt;
	logic [4:0] nblocks;
	logic [15:0] mask;
	logic [16:0] mask_w;

	assign prn_ext = {2'b00, prn_q};
	assign slot = {prn_ext[PRN_IDX_W-1:0], id_q};
	assign in_ready = (state_q == F_IDLE) && !msg_wait_q;

	always_comb begin
		bad = (prn_q == 6'd0) || ({3'b000, prn_q} >= 9'(NUM_PRN));
		pkr = (id_q >= PKR_FIRST_ID);
		max_age = pkr ? pkr_max_age : kroot_max_age;
		age = ep_q - rd_q.first_epoch;
		expired = rd_q.active && !rd_q.done && rd_q.has_first && ep_ok_q && (max_age != 32'd0)
			&& (ep_q >= rd_q.first_epoch) && (age >= max_age);
		restart = !rd_q.active || rd_q.done || expired;
		nxt = rd_q;
		if (restart) begin
			nxt.active = 1'b1;
			nxt.done = 1'b0;
			nxt.has_first = ep_ok_q;
			nxt.first_epoch = ep_q;
			nxt.rx_map = 16'd0;
		end
		nxt.rx_map = nxt.rx_map | (16'd1 << blk_q);
		if (blk_q == 4'd0) begin
			nxt.nma = nma_q;
			nxt.nb = head_q[63:60];
		end
		nblocks = nxt.rx_map[0] ? nb_to_blocks(pkr, nxt.nb) : 5'd0;
		mask_w = (17'd1 << nblocks) - 17'd1;
		mask = mask_w[15:0];
		complete = (nblocks != 5'd0) && ((nxt.rx_map & mask) == mask);
		if (complete) nxt.done = 1'b1;
		kr_next = exp_kroot_q;
		pk_next = exp_pkr_q;
		if (expired && !bad) begin
			if (pkr) begin
				if (exp_pkr_q != 32'hFFFF_FFFF) pk_next = exp_pkr_q + 32'd1;
			end else if (exp_kroot_q != 32'hFFFF_FFFF) begin
				kr_next = exp_kroot_q + 32'd1;
			end
		end
		q_cmd.kind = bad ? ST_REJECT : (complete ? ST_WORD : ST_STORED);
		q_cmd.prn = prn_q;
		q_cmd.id = id_q;
		q_cmd.nma = nxt.nma;
		q_cmd.nblocks = nblocks;
		q_cmd.slot = slot;
		q_cmd.epoch = ep_q;
		q_cmd.exp_kroot = kr_next;
		q_cmd.exp_pkr = pk_next;
	end

	assign q_push = (state_q == F_EVAL) && !q_full;
	assign blk_we = q_push && !bad;
	assign blk_waddr = {slot, blk_q};
	assign blk_wdata = {head_q, tail_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLEAR;
			clr_q <= '0;
			msg_wait_q <= 1'b0;
			exp_kroot_q <= 32'd0;
			exp_pkr_q <= 32'd0;
		end else begin
			if (msg_done) msg_wait_q <= 1'b0;
			unique case (state_q)
				F_CLEAR: begin
					clr_q <= clr_q + (SLOT_W + 1)'(1);
					if (clr_q == (SLOT_W + 1)'(NUM_SLOTS - 1)) state_q <= F_IDLE;
				end
				F_IDLE: begin
					if (in_valid && in_ready) state_q <= F_READ;
				end
				F_READ: state_q <= F_EVAL;
				F_EVAL: begin
					if (!q_full) begin
						exp_kroot_q <= kr_next;
						exp_pkr_q <= pk_next;
						if (!bad && complete) msg_wait_q <= 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_CLEAR) slot_mem[clr_q[SLOT_W-1:0]] <= '0;
		else if (blk_we) slot_mem[slot] <= nxt;
		if (state_q == F_READ) rd_q <= slot_mem[slot];
		if (in_valid && in_ready) begin
			prn_q <= prn;
			id_q <= dsm_header_byte[7:4];
			blk_q <= dsm_header_byte[3:0];
			head_q <= data_head;
			tail_q <= data_tail;
			nma_q <= nma_hdr;
			ep_q <= epoch_seconds;
			ep_ok_q <= epoch_valid;
		end
	end
endmodule

[hdl/dsmr_back.sv]
// Back part: holds the block store and emits status results and message words.
`timescale 1ns / 1ps
module dsmr_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input dsmr_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic msg_done,
	input logic blk_we,
	input logic [dsmr_pkg::BLK_ADDR_W-1:0] blk_waddr,
	input logic [dsmr_pkg::BLOCK_W-1:0] blk_wdata,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [5:0] out_prn,
	output logic [3:0] dsm_id,
	output logic is_pkr,
	output logic [7:0] out_nma_hdr,
	output logic [4:0] num_blocks,
	output logic [4:0] word_index,
	output logic [63:0] data_word,
	output logic last,
	output logic [31:0] expired_kroot_count,
	output logic [31:0] expired_pkr_count,
	output logic [31:0] last_epoch
);
	import dsmr_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_RUN = 3'b010,
		B_LOAD = 3'b100
	} bstate_t;

	bstate_t state_q;
	logic [BLOCK_W-1:0] blk_mem [NUM_SLOTS * BLOCKS_PER_DSM];
	logic [BLOCK_W-1:0] rdata_q;
	cmd_t cmd_q;
	logic [BUF_W-1:0] buf_q;
	logic [4:0] cnt_q, blk_q, widx_q;
	logic out_valid_q, out_free, all_read, do_read, do_emit, emit_last, take_status;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign all_read = (blk_q == cmd_q.nblocks);
	assign do_read = (state_q == B_RUN) && (cnt_q < 5'd8) && !all_read;
	assign do_emit = (state_q == B_RUN) && !do_read && out_free;
	assign emit_last = all_read && (cnt_q <= 5'd8);
	assign take_status = (state_q == B_IDLE) && !q_empty && out_free && (q_cmd.kind != ST_WORD);
	assign q_pop = (state_q == B_IDLE) && !q_empty && (out_free || q_cmd.kind == ST_WORD);
	assign msg_done = do_emit && emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (take_status || do_emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_pop && q_cmd.kind == ST_WORD) state_q <= B_RUN;
				end
				B_RUN: begin
					if (do_read) state_q <= B_LOAD;
					else if (do_emit && emit_last) state_q <= B_IDLE;
				end
				B_LOAD: state_q <= B_RUN;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
		if (do_read) begin
			rdata_q <= blk_mem[{cmd_q.slot, blk_q[BLK_W-1:0]}];
			blk_q <= blk_q + 5'd1;
		end
		if (q_pop && q_cmd.kind == ST_WORD) begin
			cmd_q <= q_cmd;
			blk_q <= 5'd0;
			cnt_q <= 5'd0;
			widx_q <= 5'd0;
			buf_q <= '0;
		end
		if (state_q == B_LOAD) begin
			buf_q <= buf_q | ({rdata_q, 56'd0} >> {cnt_q[2:0], 3'b000});
			cnt_q <= cnt_q + 5'd13;
		end
		if (do_emit) begin
			buf_q <= buf_q << 64;
			cnt_q <= (cnt_q >= 5'd8) ? cnt_q - 5'd8 : 5'd0;
			widx_q <= widx_q + 5'd1;
			status <= ST_WORD;
			out_prn <= cmd_q.prn;
			dsm_id <= cmd_q.id;
			is_pkr <= (cmd_q.id >= PKR_FIRST_ID);
			out_nma_hdr <= cmd_q.nma;
			num_blocks <= cmd_q.nblocks;
			word_index <= widx_q;
			data_word <= buf_q[BUF_W-1 -: 64];
			last <= emit_last;
			expired_kroot_count <= cmd_q.exp_kroot;
			expired_pkr_count <= cmd_q.exp_pkr;
			last_epoch <= cmd_q.epoch;
		end else if (take_status) begin
			status <= q_cmd.kind;
			out_prn <= q_cmd.prn;
			dsm_id <= q_cmd.id;
			is_pkr <= (q_cmd.id >= PKR_FIRST_ID);
			out_nma_hdr <= 8'd0;
			num_blocks <= 5'd0;
			word_index <= 5'd0;
			data_word <= 64'd0;
			last <= 1'b1;
			expired_kroot_count <= q_cmd.exp_kroot;
			expired_pkr_count <= q_cmd.exp_pkr;
			last_epoch <= q_cmd.epoch;
		end
	end
endmodule

[hdl/dsm_block_reassembler.sv]
// Top level of the DSM block reassembler: configuration registers, front, queue and back.
// An item passes the read and evaluate states of the front part before it is queued;
// the back part then registers its status result. A completed message is read from the block
// store one block at a time and emitted as 64-bit words; block reads take priority over words.
// While a message is being read out, the front part accepts no new item.
// After reset a clearing pass zeroes all NUM_PRN*16 slot-table entries; no item is accepted.
`timescale 1ns / 1ps
module dsm_block_reassembler (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [5:0] prn,
	input logic [7:0] dsm_header_byte,
	input logic [63:0] data_head,
	input logic [39:0] data_tail,
	input logic [7:0] nma_hdr,
	input logic [31:0] epoch_seconds,
	input logic epoch_valid,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [5:0] out_prn,
	output logic [3:0] dsm_id,
	output logic is_pkr,
	output logic [7:0] out_nma_hdr,
	output logic [4:0] num_blocks,
	output logic [4:0] word_index,
	output logic [63:0] data_word,
	output logic last,
	output logic [31:0] expired_kroot_count,
	output logic [31:0] expired_pkr_count,
	output logic [31:0] last_epoch
);
	import dsmr_pkg::*;

	logic [31:0] kroot_age_q, pkr_age_q;
	logic q_full, q_empty, q_push, q_pop, msg_done, blk_we;
	cmd_t push_cmd, head_cmd;
	logic [BLK_ADDR_W-1:0] blk_waddr;
	logic [BLOCK_W-1:0] blk_wdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kroot_age_q <= 32'd0;
			pkr_age_q <= 32'd0;
		end else if (cfg_valid) begin
			if (cfg_index) pkr_age_q <= cfg_data;
			else kroot_age_q <= cfg_data;
		end
	end

	dsmr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.prn(prn), .dsm_header_byte(dsm_header_byte),
		.data_head(data_head), .data_tail(data_tail),
		.nma_hdr(nma_hdr), .epoch_seconds(epoch_seconds), .epoch_valid(epoch_valid),
		.kroot_max_age(kroot_age_q), .pkr_max_age(pkr_age_q),
		.q_full(q_full), .q_push(q_push), .q_cmd(push_cmd),
		.msg_done(msg_done),
		.blk_we(blk_we), .blk_waddr(blk_waddr), .blk_wdata(blk_wdata)
	);

	dsmr_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_cmd(push_cmd),
		.pop(q_pop), .head_cmd(head_cmd),
		.full(q_full), .empty(q_empty)
	);

	dsmr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_cmd(head_cmd), .q_pop(q_pop), .msg_done(msg_done),
		.blk_we(blk_we), .blk_waddr(blk_waddr), .blk_wdata(blk_wdata),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .out_prn(out_prn), .dsm_id(dsm_id), .is_pkr(is_pkr),
		.out_nma_hdr(out_nma_hdr), .num_blocks(num_blocks),
		.word_index(word_index), .data_word(data_word), .last(last),
		.expired_kroot_count(expired_kroot_count), .expired_pkr_count(expired_pkr_count),
		.last_epoch(last_epoch)
	);
endmodule
